// ===== rtl/arsg_pkg.sv =====
// Shared types and constants of the ring allreduce schedule generator.
// Used by the divider, the top level, the checker and the testbench.
package arsg_pkg;

	localparam int MAX_RANKS  = 64;
	localparam int MAX_LEVELS = 6;
	localparam int LVL_W      = $clog2(MAX_LEVELS);
	localparam int CNT_W      = $clog2(MAX_LEVELS + 1);
	localparam int RANK_W     = $clog2(MAX_RANKS + 1);
	localparam int NUM_W      = 32 + RANK_W;
	localparam int DCNT_W     = $clog2(NUM_W + 1);

	localparam logic [2:0] REG_NUM_RANKS    = 3'd0;
	localparam logic [2:0] REG_RANK_INDEX   = 3'd1;
	localparam logic [2:0] REG_TOTAL_LENGTH = 3'd2;
	localparam logic [2:0] REG_ELEM_BYTES   = 3'd3;
	localparam logic [2:0] REG_COMM_NOTE    = 3'd4;
	localparam logic [2:0] REG_REDUCE_NOTE  = 3'd5;
	localparam logic [2:0] REG_REDUCE_BASE  = 3'd6;
	localparam logic [2:0] REG_COMM_BASE    = 3'd7;

	localparam logic [1:0] SEND_NONE    = 2'd0;
	localparam logic [1:0] SEND_COMM    = 2'd1;
	localparam logic [1:0] SEND_INPLACE = 2'd2;

	typedef enum logic [4:0] {
		ST_IDLE, ST_B_INIT, ST_B_FTEST, ST_B_FWAIT, ST_B_TAIL, ST_B_SSEL, ST_B_SWR,
		ST_B_RDIV, ST_B_RWAIT, ST_B_DSEL, ST_B_DDIV, ST_B_DWAIT, ST_P_START,
		ST_W_STEP, ST_W_R, ST_W_ADV, ST_AFTER_WALK, ST_R_SET, ST_R_FIN, ST_SEND_DEC,
		ST_S_SET, ST_S_FIN, ST_G_FIND, ST_G_SET, ST_G_FIN, ST_SP_LO, ST_SP_LO_W,
		ST_SP_HI, ST_SP_HI_W, ST_DONE
	} state_t;

	typedef struct packed {
		logic              start;
		logic [NUM_W-1:0]  num;
		logic [RANK_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [NUM_W-1:0]  quo;
		logic [RANK_W-1:0] rem;
	} div_rsp_t;

	typedef struct packed {
		logic        do_reduce;
		logic        scale_by_ranks;
		logic [47:0] reduce_src_offset;
		logic [47:0] reduce_dst_offset;
		logic [31:0] reduce_elems;
		logic [1:0]  send_kind;
		logic [5:0]  target_rank;
		logic [47:0] send_src_offset;
		logic [47:0] send_dst_offset;
		logic [34:0] send_bytes;
		logic [15:0] notification_id;
		logic        final_phase;
	} res_t;

endpackage

// ===== rtl/arsg_chan_if.sv =====
// Valid/ready channels of the schedule generator: phase in, descriptor out.
// No dependencies.
interface arsg_in_if;
	logic       valid;
	logic       ready;
	logic [6:0] phase_index;
	modport source(output valid, output phase_index, input ready);
	modport sink(input valid, input phase_index, output ready);
endinterface

interface arsg_out_if;
	logic        valid;
	logic        ready;
	logic        do_reduce;
	logic        scale_by_ranks;
	logic [47:0] reduce_src_offset;
	logic [47:0] reduce_dst_offset;
	logic [31:0] reduce_elems;
	logic [1:0]  send_kind;
	logic [5:0]  target_rank;
	logic [47:0] send_src_offset;
	logic [47:0] send_dst_offset;
	logic [34:0] send_bytes;
	logic [15:0] notification_id;
	logic        final_phase;
	modport source(output valid, input ready, output do_reduce, output scale_by_ranks,
		output reduce_src_offset, output reduce_dst_offset, output reduce_elems,
		output send_kind, output target_rank, output send_src_offset,
		output send_dst_offset, output send_bytes, output notification_id,
		output final_phase);
	modport sink(input valid, output ready, input do_reduce, input scale_by_ranks,
		input reduce_src_offset, input reduce_dst_offset, input reduce_elems,
		input send_kind, input target_rank, input send_src_offset,
		input send_dst_offset, input send_bytes, input notification_id,
		input final_phase);
endinterface

// ===== rtl/arsg_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on arsg_pkg.
module arsg_div (
	input  logic               clk,
	input  logic               arst_n,
	input  arsg_pkg::div_req_t req,
	output arsg_pkg::div_rsp_t rsp
);

	logic [arsg_pkg::NUM_W-1:0]  work_q;
	logic [arsg_pkg::RANK_W-1:0] rem_q;
	logic [arsg_pkg::RANK_W-1:0] den_q;
	logic [arsg_pkg::DCNT_W-1:0] cnt_q;
	logic                        done_q;
	logic [arsg_pkg::RANK_W:0]   trial;
	logic                        take;

	assign trial = {rem_q, work_q[arsg_pkg::NUM_W-1]};
	assign take  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q <= arsg_pkg::DCNT_W'(arsg_pkg::NUM_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == arsg_pkg::DCNT_W'(1)) done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			work_q <= req.num;
			den_q  <= req.den;
			rem_q  <= '0;
		end else if (cnt_q != '0) begin
			work_q <= {work_q[arsg_pkg::NUM_W-2:0], take};
			rem_q  <= take ? arsg_pkg::RANK_W'(trial - {1'b0, den_q})
			               : trial[arsg_pkg::RANK_W-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = work_q;
	assign rsp.rem  = rem_q;

endmodule

// ===== rtl/allreduce_ring_schedule_generator.sv =====
// Top level of the nested-ring allreduce schedule generator.
// Depends on arsg_pkg, arsg_chan_if and arsg_div.
//
//   port      direction  handshake            carries
//   in_ch     sink       valid/ready          phase_index
//   out_ch    source     valid/ready          one phase descriptor
//   APB       slave      psel/penable/pready  eight config registers, 8-byte stride
//
// One item at a time; ready is high only while the sequencer is idle.
// The first item after reset or a config write first factors the rank count.
// An item whose phase lies in the reduce-scatter half then walks the steps
// before it. Nearly all of the time goes to the single divider.
// A stalled result waits in the output register.
module allreduce_ring_schedule_generator (
	input  logic               clk,
	input  logic               arst_n,
	arsg_in_if.sink            in_ch,
	arsg_out_if.source         out_ch,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [5:0]         paddr,
	input  logic [63:0]        pwdata,
	output logic [63:0]        prdata,
	output logic               pready
);

	localparam int ML = arsg_pkg::MAX_LEVELS;
	localparam int LW = arsg_pkg::LVL_W;
	localparam int CW = arsg_pkg::CNT_W;
	localparam int RW = arsg_pkg::RANK_W;

	logic [6:0]  num_ranks_q;
	logic [5:0]  rank_index_q;
	logic [31:0] total_length_q;
	logic [3:0]  element_bytes_q;
	logic [15:0] comm_note_q;
	logic [15:0] reduce_note_q;
	logic [39:0] reduce_base_q;
	logic [39:0] comm_base_q;
	logic        tables_ready_q;

	logic [RW-1:0] factor_q [ML];
	logic [RW-1:0] stride_q [ML];
	logic [RW-1:0] weight_q [ML];
	logic [5:0]    digit_q  [ML];
	logic [CW-1:0] cnt_q;
	logic [5:0]    stotal_q;
	logic [RW-1:0] eff_q;
	logic [5:0]    rmod_q;

	arsg_pkg::state_t state_q, state_d, ret_q;
	logic [RW-1:0] n_q;
	logic [3:0]    f_q;
	logic [CW-1:0] i_q;
	logic [RW-1:0] acc_q;
	logic [5:0]    r_q;
	logic [LW-1:0] sel_q;
	logic [6:0]    p_q;
	logic [5:0]    c_q, l_q, j_q;
	logic [47:0]   local_q, remote_q, local_a_q, remote_b_q;
	logic [LW-1:0] lvl_a_q, lvl_b_q;
	logic [5:0]    lp_a_q, lp_b_q;
	logic [RW-1:0] st_q;
	logic [32:0]   lo_q, hi_q;
	arsg_pkg::res_t res_q, out_q;
	logic          out_valid_q;

	arsg_pkg::div_req_t div_req;
	arsg_pkg::div_rsp_t div_rsp;

	arsg_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp));

	logic          cfg_wr, in_acc, out_load;
	logic [RW-1:0] f_sel, stride_sel, weight_sel;
	logic [5:0]    d_sel;
	logic [12:0]   pre;
	logic [5:0]    id_l;
	logic [1:0]    id_k;
	logic [7:0]    id_raw;
	logic [6:0]    id_w;
	logic [RW-1:0] st_next;
	logic [12:0]   st_sum;
	logic [5:0]    nb;
	logic [12:0]   dw;
	logic [32:0]   span_w;
	logic [36:0]   span_b, lo_b;
	logic [47:0]   local_new;
	logic          hit_a, hit_b;
	logic [6:0]    two_s, s_ext;
	logic [RW-1:0] n_clamp;
	logic [CW-1:0] cnt_tail;
	logic [7:0]    ff;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign in_acc = in_ch.valid && in_ch.ready;

	assign f_sel      = factor_q[sel_q];
	assign stride_sel = stride_q[sel_q];
	assign weight_sel = weight_q[sel_q];
	assign d_sel      = digit_q[sel_q];

	always_comb begin
		pre = '0;
		for (int k = 0; k < ML; k++) begin
			if (LW'(k) < sel_q) pre = pre + 13'(digit_q[k] * stride_q[k]);
		end
	end

	always_comb begin
		id_l = l_q;
		id_k = 2'd1;
		unique case (state_q)
			arsg_pkg::ST_W_R:   id_k = 2'd2;
			arsg_pkg::ST_R_SET: begin
				id_l = lp_a_q;
				id_k = 2'd2;
			end
			arsg_pkg::ST_S_SET: id_l = lp_b_q;
			arsg_pkg::ST_G_SET: id_k = 2'd0;
			default: ;
		endcase
	end

	assign id_raw  = {2'b0, d_sel} + {1'b0, f_sel} - {2'b0, id_l} - {6'b0, id_k};
	assign id_w    = (id_raw >= {1'b0, f_sel}) ? 7'(id_raw - {1'b0, f_sel}) : id_raw[6:0];
	assign st_sum  = pre + 13'(id_w * stride_sel);
	assign st_next = st_sum[RW-1:0];

	assign dw = 13'(d_sel * weight_sel);
	assign nb = ({1'b0, d_sel} + 7'd1 == f_sel) ? 6'({7'b0, rmod_q} - dw)
	                                           : 6'({7'b0, rmod_q} + {6'b0, weight_sel});

	assign span_w    = hi_q - lo_q;
	assign span_b    = 37'(span_w * element_bytes_q);
	assign lo_b      = 37'(lo_q * element_bytes_q);
	assign local_new = local_q + {11'b0, span_b};

	assign s_ext  = {1'b0, stotal_q};
	assign two_s  = {stotal_q, 1'b0};
	assign hit_a  = (p_q != '0) && ({1'b0, c_q} == p_q - 7'd1);
	assign hit_b  = {1'b0, c_q} == p_q;

	assign n_clamp  = (num_ranks_q == '0) ? RW'(1)
	                : (num_ranks_q > RW'(arsg_pkg::MAX_RANKS)) ? RW'(arsg_pkg::MAX_RANKS)
	                : num_ranks_q;
	assign cnt_tail = (n_q > RW'(1) && cnt_q < CW'(ML)) ? cnt_q + 1'b1 : cnt_q;
	assign ff       = f_q * f_q;

	assign out_load = (state_q == arsg_pkg::ST_DONE) && (!out_valid_q || out_ch.ready);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			arsg_pkg::ST_IDLE:
				if (in_acc) state_d = tables_ready_q ? arsg_pkg::ST_P_START : arsg_pkg::ST_B_INIT;
			arsg_pkg::ST_B_INIT:  state_d = arsg_pkg::ST_B_FTEST;
			arsg_pkg::ST_B_FTEST:
				state_d = (ff <= {1'b0, n_q}) ? arsg_pkg::ST_B_FWAIT : arsg_pkg::ST_B_TAIL;
			arsg_pkg::ST_B_FWAIT: if (div_rsp.done) state_d = arsg_pkg::ST_B_FTEST;
			arsg_pkg::ST_B_TAIL:  state_d = arsg_pkg::ST_B_SSEL;
			arsg_pkg::ST_B_SSEL:
				state_d = (i_q == '0) ? arsg_pkg::ST_B_RDIV : arsg_pkg::ST_B_SWR;
			arsg_pkg::ST_B_SWR:   state_d = arsg_pkg::ST_B_SSEL;
			arsg_pkg::ST_B_RDIV:  state_d = arsg_pkg::ST_B_RWAIT;
			arsg_pkg::ST_B_RWAIT: if (div_rsp.done) state_d = arsg_pkg::ST_B_DSEL;
			arsg_pkg::ST_B_DSEL:
				state_d = (i_q == cnt_q) ? arsg_pkg::ST_P_START : arsg_pkg::ST_B_DDIV;
			arsg_pkg::ST_B_DDIV:  state_d = arsg_pkg::ST_B_DWAIT;
			arsg_pkg::ST_B_DWAIT: if (div_rsp.done) state_d = arsg_pkg::ST_B_DSEL;
			arsg_pkg::ST_P_START: begin
				if (p_q > two_s || stotal_q == '0) state_d = arsg_pkg::ST_DONE;
				else if (p_q <= s_ext) state_d = arsg_pkg::ST_W_STEP;
				else state_d = arsg_pkg::ST_SEND_DEC;
			end
			arsg_pkg::ST_W_STEP: begin
				if (hit_b || (hit_a && p_q == s_ext)) state_d = arsg_pkg::ST_AFTER_WALK;
				else state_d = arsg_pkg::ST_SP_LO;
			end
			arsg_pkg::ST_W_R:     state_d = arsg_pkg::ST_SP_LO;
			arsg_pkg::ST_W_ADV:   state_d = arsg_pkg::ST_W_STEP;
			arsg_pkg::ST_AFTER_WALK:
				state_d = (p_q != '0) ? arsg_pkg::ST_R_SET : arsg_pkg::ST_SEND_DEC;
			arsg_pkg::ST_R_SET:   state_d = arsg_pkg::ST_SP_LO;
			arsg_pkg::ST_R_FIN:   state_d = arsg_pkg::ST_SEND_DEC;
			arsg_pkg::ST_SEND_DEC: begin
				if (p_q < s_ext) state_d = arsg_pkg::ST_S_SET;
				else if (p_q < two_s) state_d = arsg_pkg::ST_G_FIND;
				else state_d = arsg_pkg::ST_DONE;
			end
			arsg_pkg::ST_S_SET:   state_d = arsg_pkg::ST_SP_LO;
			arsg_pkg::ST_S_FIN:   state_d = arsg_pkg::ST_DONE;
			arsg_pkg::ST_G_FIND:
				if ({1'b0, j_q} < f_sel - 1'b1) state_d = arsg_pkg::ST_G_SET;
			arsg_pkg::ST_G_SET:   state_d = arsg_pkg::ST_SP_LO;
			arsg_pkg::ST_G_FIN:   state_d = arsg_pkg::ST_DONE;
			arsg_pkg::ST_SP_LO:   state_d = arsg_pkg::ST_SP_LO_W;
			arsg_pkg::ST_SP_LO_W: if (div_rsp.done) state_d = arsg_pkg::ST_SP_HI;
			arsg_pkg::ST_SP_HI:   state_d = arsg_pkg::ST_SP_HI_W;
			arsg_pkg::ST_SP_HI_W: if (div_rsp.done) state_d = ret_q;
			arsg_pkg::ST_DONE:    if (out_load) state_d = arsg_pkg::ST_IDLE;
			default:              state_d = arsg_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ch.ready   = state_q == arsg_pkg::ST_IDLE;
		div_req.start = 1'b0;
		div_req.num   = '0;
		div_req.den   = eff_q;
		unique case (state_q)
			arsg_pkg::ST_B_FTEST: begin
				div_req.start = ff <= {1'b0, n_q};
				div_req.num   = {{(arsg_pkg::NUM_W-RW){1'b0}}, n_q};
				div_req.den   = {{(RW-4){1'b0}}, f_q};
			end
			arsg_pkg::ST_B_RDIV: begin
				div_req.start = 1'b1;
				div_req.num   = {{(arsg_pkg::NUM_W-6){1'b0}}, rank_index_q};
			end
			arsg_pkg::ST_B_DDIV: begin
				div_req.start = 1'b1;
				div_req.num   = {{(arsg_pkg::NUM_W-6){1'b0}}, r_q};
				div_req.den   = f_sel;
			end
			arsg_pkg::ST_SP_LO: begin
				div_req.start = 1'b1;
				div_req.num   = arsg_pkg::NUM_W'(total_length_q * st_q)
				              + arsg_pkg::NUM_W'(eff_q - 1'b1);
			end
			arsg_pkg::ST_SP_HI: begin
				div_req.start = 1'b1;
				div_req.num   = arsg_pkg::NUM_W'(total_length_q * RW'(st_q + stride_sel))
				              + arsg_pkg::NUM_W'(eff_q - 1'b1);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= arsg_pkg::ST_IDLE;
			out_valid_q     <= 1'b0;
			tables_ready_q  <= 1'b0;
			cnt_q           <= '0;
			num_ranks_q     <= 7'd1;
			rank_index_q    <= '0;
			total_length_q  <= '0;
			element_bytes_q <= 4'd4;
			comm_note_q     <= '0;
			reduce_note_q   <= '0;
			reduce_base_q   <= '0;
			comm_base_q     <= '0;
		end else begin
			state_q <= state_d;
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
			if (state_q == arsg_pkg::ST_B_INIT) cnt_q <= '0;
			if (state_q == arsg_pkg::ST_B_FWAIT && div_rsp.done && div_rsp.rem == '0
			    && cnt_q < CW'(ML)) cnt_q <= cnt_q + 1'b1;
			if (state_q == arsg_pkg::ST_B_TAIL) cnt_q <= cnt_tail;
			if (cfg_wr) tables_ready_q <= 1'b0;
			else if (state_q == arsg_pkg::ST_B_DSEL && i_q == cnt_q) tables_ready_q <= 1'b1;
			if (cfg_wr) begin
				unique case (paddr[5:3])
					arsg_pkg::REG_NUM_RANKS:    num_ranks_q     <= pwdata[6:0];
					arsg_pkg::REG_RANK_INDEX:   rank_index_q    <= pwdata[5:0];
					arsg_pkg::REG_TOTAL_LENGTH: total_length_q  <= pwdata[31:0];
					arsg_pkg::REG_ELEM_BYTES:   element_bytes_q <= pwdata[3:0];
					arsg_pkg::REG_COMM_NOTE:    comm_note_q     <= pwdata[15:0];
					arsg_pkg::REG_REDUCE_NOTE:  reduce_note_q   <= pwdata[15:0];
					arsg_pkg::REG_REDUCE_BASE:  reduce_base_q   <= pwdata[39:0];
					arsg_pkg::REG_COMM_BASE:    comm_base_q     <= pwdata[39:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) out_q <= res_q;
		unique case (state_q)
			arsg_pkg::ST_IDLE: if (in_acc) p_q <= in_ch.phase_index;
			arsg_pkg::ST_B_INIT: begin
				n_q   <= n_clamp;
				eff_q <= n_clamp;
				f_q   <= 4'd2;
			end
			arsg_pkg::ST_B_FWAIT: if (div_rsp.done) begin
				if (div_rsp.rem == '0) begin
					if (cnt_q < CW'(ML)) factor_q[cnt_q[LW-1:0]] <= {3'b0, f_q};
					else factor_q[ML-1] <= RW'(factor_q[ML-1] * f_q);
					n_q <= div_rsp.quo[RW-1:0];
				end else begin
					f_q <= f_q + 1'b1;
				end
			end
			arsg_pkg::ST_B_TAIL: begin
				if (n_q > RW'(1)) begin
					if (cnt_q < CW'(ML)) factor_q[cnt_q[LW-1:0]] <= n_q;
					else factor_q[ML-1] <= RW'(factor_q[ML-1] * n_q);
				end
				i_q   <= cnt_tail;
				acc_q <= RW'(1);
			end
			arsg_pkg::ST_B_SSEL: if (i_q != '0) sel_q <= LW'(i_q - 1'b1);
			arsg_pkg::ST_B_SWR: begin
				stride_q[sel_q] <= acc_q;
				acc_q           <= RW'(acc_q * f_sel);
				i_q             <= i_q - 1'b1;
			end
			arsg_pkg::ST_B_RWAIT: if (div_rsp.done) begin
				rmod_q   <= div_rsp.rem[5:0];
				r_q      <= div_rsp.rem[5:0];
				i_q      <= '0;
				acc_q    <= RW'(1);
				stotal_q <= '0;
			end
			arsg_pkg::ST_B_DSEL: if (i_q != cnt_q) sel_q <= i_q[LW-1:0];
			arsg_pkg::ST_B_DWAIT: if (div_rsp.done) begin
				digit_q[sel_q]  <= div_rsp.rem[5:0];
				weight_q[sel_q] <= acc_q;
				acc_q           <= RW'(acc_q * f_sel);
				r_q             <= div_rsp.quo[5:0];
				stotal_q        <= 6'(stotal_q + f_sel - 1'b1);
				i_q             <= i_q + 1'b1;
			end
			arsg_pkg::ST_P_START: begin
				res_q    <= {{($bits(arsg_pkg::res_t)-1){1'b0}}, p_q == two_s};
				c_q      <= '0;
				l_q      <= '0;
				sel_q    <= '0;
				local_q  <= '0;
				remote_q <= '0;
			end
			arsg_pkg::ST_W_STEP: begin
				if (hit_a) begin
					lvl_a_q   <= sel_q;
					lp_a_q    <= l_q;
					local_a_q <= local_q;
				end
				if (hit_b) begin
					lvl_b_q    <= sel_q;
					lp_b_q     <= l_q;
					remote_b_q <= remote_q;
				end
				st_q  <= st_next;
				ret_q <= arsg_pkg::ST_W_R;
			end
			arsg_pkg::ST_W_R: begin
				remote_q <= remote_q + {11'b0, span_b};
				st_q     <= st_next;
				ret_q    <= arsg_pkg::ST_W_ADV;
			end
			arsg_pkg::ST_W_ADV: begin
				local_q <= local_new;
				c_q     <= c_q + 1'b1;
				if ({1'b0, l_q} + 7'd1 == f_sel - 1'b1) begin
					l_q      <= '0;
					sel_q    <= sel_q + 1'b1;
					remote_q <= local_new;
				end else begin
					l_q <= l_q + 1'b1;
				end
			end
			arsg_pkg::ST_AFTER_WALK: sel_q <= lvl_a_q;
			arsg_pkg::ST_R_SET: begin
				st_q  <= st_next;
				ret_q <= arsg_pkg::ST_R_FIN;
			end
			arsg_pkg::ST_R_FIN: begin
				res_q.do_reduce         <= 1'b1;
				res_q.scale_by_ranks    <= p_q == s_ext;
				res_q.reduce_src_offset <= {8'b0, comm_base_q} + local_a_q;
				res_q.reduce_dst_offset <= {8'b0, reduce_base_q} + {11'b0, lo_b};
				res_q.reduce_elems      <= span_w[31:0];
			end
			arsg_pkg::ST_SEND_DEC: begin
				if (p_q < s_ext) sel_q <= lvl_b_q;
				else sel_q <= LW'(cnt_q - 1'b1);
				j_q <= 6'(p_q - s_ext);
			end
			arsg_pkg::ST_S_SET: begin
				st_q  <= st_next;
				ret_q <= arsg_pkg::ST_S_FIN;
			end
			arsg_pkg::ST_S_FIN: begin
				res_q.send_kind       <= arsg_pkg::SEND_COMM;
				res_q.target_rank     <= nb;
				res_q.send_src_offset <= {8'b0, reduce_base_q} + {11'b0, lo_b};
				res_q.send_dst_offset <= {8'b0, comm_base_q} + remote_b_q;
				res_q.send_bytes      <= span_b[34:0];
				res_q.notification_id <= comm_note_q + {9'b0, p_q};
			end
			arsg_pkg::ST_G_FIND: begin
				if ({1'b0, j_q} < f_sel - 1'b1) begin
					l_q <= j_q;
				end else begin
					j_q   <= 6'(j_q - (f_sel - 1'b1));
					sel_q <= sel_q - 1'b1;
				end
			end
			arsg_pkg::ST_G_SET: begin
				st_q  <= st_next;
				ret_q <= arsg_pkg::ST_G_FIN;
			end
			arsg_pkg::ST_G_FIN: begin
				res_q.send_kind       <= arsg_pkg::SEND_INPLACE;
				res_q.target_rank     <= nb;
				res_q.send_src_offset <= {8'b0, reduce_base_q} + {11'b0, lo_b};
				res_q.send_dst_offset <= {8'b0, reduce_base_q} + {11'b0, lo_b};
				res_q.send_bytes      <= span_b[34:0];
				res_q.notification_id <= reduce_note_q + 16'(p_q - s_ext);
			end
			arsg_pkg::ST_SP_LO_W: if (div_rsp.done) lo_q <= div_rsp.quo[32:0];
			arsg_pkg::ST_SP_HI_W: if (div_rsp.done) hi_q <= div_rsp.quo[32:0];
			default: ;
		endcase
	end

	always_comb begin
		unique case (paddr[5:3])
			arsg_pkg::REG_NUM_RANKS:    prdata = {57'b0, num_ranks_q};
			arsg_pkg::REG_RANK_INDEX:   prdata = {58'b0, rank_index_q};
			arsg_pkg::REG_TOTAL_LENGTH: prdata = {32'b0, total_length_q};
			arsg_pkg::REG_ELEM_BYTES:   prdata = {60'b0, element_bytes_q};
			arsg_pkg::REG_COMM_NOTE:    prdata = {48'b0, comm_note_q};
			arsg_pkg::REG_REDUCE_NOTE:  prdata = {48'b0, reduce_note_q};
			arsg_pkg::REG_REDUCE_BASE:  prdata = {24'b0, reduce_base_q};
			arsg_pkg::REG_COMM_BASE:    prdata = {24'b0, comm_base_q};
			default:                    prdata = '0;
		endcase
	end

	assign out_ch.valid             = out_valid_q;
	assign out_ch.do_reduce         = out_q.do_reduce;
	assign out_ch.scale_by_ranks    = out_q.scale_by_ranks;
	assign out_ch.reduce_src_offset = out_q.reduce_src_offset;
	assign out_ch.reduce_dst_offset = out_q.reduce_dst_offset;
	assign out_ch.reduce_elems      = out_q.reduce_elems;
	assign out_ch.send_kind         = out_q.send_kind;
	assign out_ch.target_rank       = out_q.target_rank;
	assign out_ch.send_src_offset   = out_q.send_src_offset;
	assign out_ch.send_dst_offset   = out_q.send_dst_offset;
	assign out_ch.send_bytes        = out_q.send_bytes;
	assign out_ch.notification_id   = out_q.notification_id;
	assign out_ch.final_phase       = out_q.final_phase;

endmodule

// ===== test/arsg_schedule_checker.sv =====
// Checker for the ring allreduce schedule generator: mirrors the config
// writes, predicts each phase descriptor and compares it with the output item.
// Depends on arsg_pkg and the channel interfaces in arsg_chan_if.
module arsg_schedule_checker
	import arsg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	arsg_in_if          in_ch,
	arsg_out_if         out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output int          errors,
	output int          pending
);

	int unsigned     num_ranks_r, rank_index_r, total_len_r, elem_bytes_r;
	int unsigned     comm_note_r, reduce_note_r;
	longint unsigned reduce_base_r, comm_base_r;

	int unsigned lvl_factor[MAX_LEVELS];
	int unsigned lvl_stride[MAX_LEVELS];
	int unsigned lvl_digit[MAX_LEVELS];
	int unsigned lvl_count, eff_ranks, step_total;
	bit          levels_valid;

	res_t descriptor_queue[$];

	function automatic void rebuild_levels();
		int unsigned n, f, i, acc, r;
		n = num_ranks_r;
		if (n < 1) n = 1;
		if (n > MAX_RANKS) n = MAX_RANKS;
		eff_ranks = n;
		lvl_count = 0;
		for (f = 2; f * f <= n; f++) begin
			while (n % f == 0) begin
				if (lvl_count < MAX_LEVELS) begin
					lvl_factor[lvl_count] = f;
					lvl_count++;
				end else lvl_factor[MAX_LEVELS-1] *= f;
				n /= f;
			end
		end
		if (n > 1) begin
			if (lvl_count < MAX_LEVELS) begin
				lvl_factor[lvl_count] = n;
				lvl_count++;
			end else lvl_factor[MAX_LEVELS-1] *= n;
		end
		acc = 1;
		for (i = lvl_count; i > 0; i--) begin
			lvl_stride[i-1] = acc;
			acc *= lvl_factor[i-1];
		end
		r = rank_index_r % eff_ranks;
		acc = 1;
		step_total = 0;
		for (i = 0; i < lvl_count; i++) begin
			lvl_digit[i] = (r / acc) % lvl_factor[i];
			acc *= lvl_factor[i];
			step_total += lvl_factor[i] - 1;
		end
		levels_valid = 1;
	endfunction

	function automatic longint unsigned chunk_start(longint unsigned c);
		return (longint'(total_len_r) * c + eff_ranks - 1) / eff_ranks;
	endfunction

	function automatic longint unsigned seg_start(int unsigned lvl, int unsigned id);
		longint unsigned s;
		s = 0;
		for (int unsigned i = 0; i < lvl; i++) s += longint'(lvl_digit[i]) * lvl_stride[i];
		return s + longint'(id) * lvl_stride[lvl];
	endfunction

	function automatic longint unsigned seg_elems(longint unsigned st, int unsigned lvl);
		return chunk_start(st + lvl_stride[lvl]) - chunk_start(st);
	endfunction

	function automatic int unsigned ring_peer(int unsigned lvl);
		int unsigned r, d;
		r = 0;
		for (int unsigned i = lvl_count; i > 0; i--) begin
			d = lvl_digit[i-1];
			if (i - 1 == lvl) d = (d + 1) % lvl_factor[i-1];
			r = r * lvl_factor[i-1] + d;
		end
		return r;
	endfunction

	function automatic void locate_step(input int unsigned t, output int unsigned lvl,
			output int unsigned lp, output longint unsigned local_off,
			output longint unsigned remote_off);
		longint unsigned lo, ro;
		int unsigned c, f, d;
		lo = 0;
		ro = 0;
		c = 0;
		for (int unsigned L = 0; L < lvl_count; L++) begin
			f = lvl_factor[L];
			d = lvl_digit[L];
			ro = lo;
			for (int unsigned l = 0; l + 1 < f; l++) begin
				if (c == t) begin
					lvl = L;
					lp = l;
					local_off = lo;
					remote_off = ro;
					return;
				end
				ro += seg_elems(seg_start(L, (d + f - l - 1) % f), L) * elem_bytes_r;
				lo += seg_elems(seg_start(L, (d + f - l - 2) % f), L) * elem_bytes_r;
				c++;
			end
		end
		lvl = 0;
		lp = 0;
		local_off = lo;
		remote_off = ro;
	endfunction

	function automatic res_t predict_descriptor(int unsigned p);
		res_t e;
		int unsigned S, lvl, lp, f, d, j, c;
		longint unsigned lo, ro, st;
		e = '0;
		if (!levels_valid) rebuild_levels();
		S = step_total;
		if (p > 2 * S) return e;
		e.final_phase = (p == 2 * S);
		if (p >= 1 && p <= S) begin
			locate_step(p - 1, lvl, lp, lo, ro);
			f = lvl_factor[lvl];
			d = lvl_digit[lvl];
			st = seg_start(lvl, (d + f - lp - 2) % f);
			e.do_reduce = 1'b1;
			e.scale_by_ranks = (p == S);
			e.reduce_src_offset = 48'(comm_base_r + lo);
			e.reduce_dst_offset = 48'(reduce_base_r + chunk_start(st) * elem_bytes_r);
			e.reduce_elems = 32'(seg_elems(st, lvl));
		end
		if (p < S) begin
			locate_step(p, lvl, lp, lo, ro);
			f = lvl_factor[lvl];
			d = lvl_digit[lvl];
			st = seg_start(lvl, (d + f - lp - 1) % f);
			e.send_kind = SEND_COMM;
			e.target_rank = 6'(ring_peer(lvl));
			e.send_src_offset = 48'(reduce_base_r + chunk_start(st) * elem_bytes_r);
			e.send_dst_offset = 48'(comm_base_r + ro);
			e.send_bytes = 35'(seg_elems(st, lvl) * elem_bytes_r);
			e.notification_id = 16'(comm_note_r + p);
		end else if (p < 2 * S) begin
			j = p - S;
			c = 0;
			for (int unsigned L = lvl_count; L > 0; L--) begin
				f = lvl_factor[L-1];
				d = lvl_digit[L-1];
				for (int unsigned l = 0; l + 1 < f; l++) begin
					if (c == j) begin
						st = seg_start(L - 1, (d + f - l) % f);
						e.send_kind = SEND_INPLACE;
						e.target_rank = 6'(ring_peer(L - 1));
						e.send_src_offset = 48'(reduce_base_r + chunk_start(st) * elem_bytes_r);
						e.send_dst_offset = e.send_src_offset;
						e.send_bytes = 35'(seg_elems(st, L - 1) * elem_bytes_r);
						e.notification_id = 16'(reduce_note_r + j);
					end
					c++;
				end
			end
		end
		return e;
	endfunction

	task automatic report(string field, longint unsigned got, longint unsigned want);
		$display("mismatch %s: got %0h expected %0h", field, got, want);
		errors++;
	endtask

	task automatic compare_descriptor(res_t e);
		if (out_ch.do_reduce !== e.do_reduce)
			report("do_reduce", out_ch.do_reduce, e.do_reduce);
		if (out_ch.scale_by_ranks !== e.scale_by_ranks)
			report("scale_by_ranks", out_ch.scale_by_ranks, e.scale_by_ranks);
		if (out_ch.reduce_src_offset !== e.reduce_src_offset)
			report("reduce_src_offset", out_ch.reduce_src_offset, e.reduce_src_offset);
		if (out_ch.reduce_dst_offset !== e.reduce_dst_offset)
			report("reduce_dst_offset", out_ch.reduce_dst_offset, e.reduce_dst_offset);
		if (out_ch.reduce_elems !== e.reduce_elems)
			report("reduce_elems", out_ch.reduce_elems, e.reduce_elems);
		if (out_ch.send_kind !== e.send_kind)
			report("send_kind", out_ch.send_kind, e.send_kind);
		if (out_ch.target_rank !== e.target_rank)
			report("target_rank", out_ch.target_rank, e.target_rank);
		if (out_ch.send_src_offset !== e.send_src_offset)
			report("send_src_offset", out_ch.send_src_offset, e.send_src_offset);
		if (out_ch.send_dst_offset !== e.send_dst_offset)
			report("send_dst_offset", out_ch.send_dst_offset, e.send_dst_offset);
		if (out_ch.send_bytes !== e.send_bytes)
			report("send_bytes", out_ch.send_bytes, e.send_bytes);
		if (out_ch.notification_id !== e.notification_id)
			report("notification_id", out_ch.notification_id, e.notification_id);
		if (out_ch.final_phase !== e.final_phase)
			report("final_phase", out_ch.final_phase, e.final_phase);
	endtask

	initial begin
		errors = 0;
		pending = 0;
		num_ranks_r = 1;
		rank_index_r = 0;
		total_len_r = 0;
		elem_bytes_r = 4;
		comm_note_r = 0;
		reduce_note_r = 0;
		reduce_base_r = 0;
		comm_base_r = 0;
		levels_valid = 0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[5:3])
					REG_NUM_RANKS:    num_ranks_r = pwdata[6:0];
					REG_RANK_INDEX:   rank_index_r = pwdata[5:0];
					REG_TOTAL_LENGTH: total_len_r = pwdata[31:0];
					REG_ELEM_BYTES:   elem_bytes_r = pwdata[3:0];
					REG_COMM_NOTE:    comm_note_r = pwdata[15:0];
					REG_REDUCE_NOTE:  reduce_note_r = pwdata[15:0];
					REG_REDUCE_BASE:  reduce_base_r = pwdata[39:0];
					REG_COMM_BASE:    comm_base_r = pwdata[39:0];
				endcase
				levels_valid = 0;
			end
			if (in_ch.valid && in_ch.ready)
				descriptor_queue.insert(descriptor_queue.size(),
					predict_descriptor(in_ch.phase_index));
			if (out_ch.valid && out_ch.ready) begin
				if (descriptor_queue.size() == 0) begin
					$display("descriptor item with no phase outstanding");
					errors++;
				end else compare_descriptor(descriptor_queue.pop_front());
			end
			pending = descriptor_queue.size();
		end
	end

endmodule

// ===== test/allreduce_ring_schedule_generator_test.sv =====
// Top of the schedule generator testbench: clock, reset, config writes,
// phase stimulus and output back-pressure; verdict from arsg_schedule_checker.
// Depends on arsg_pkg, arsg_chan_if and the generator RTL.
module allreduce_ring_schedule_generator_test;
	import arsg_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [5:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;
	int          errors, pending;
	bit          idle_en;
	int          hold_req;
	int unsigned cur_ranks;

	arsg_in_if  in_ch();
	arsg_out_if out_ch();

	allreduce_ring_schedule_generator uut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	arsg_schedule_checker chk (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata), .errors(errors), .pending(pending)
	);

	initial clk = 0;
	always #4 clk = ~clk;

	initial begin
		#400000000;
		$display("CHECKS FAILED");
		$finish;
	end

	// output side: random stall bursts, plus a long hold-off on request
	initial begin
		int n;
		out_ch.ready = 0;
		forever begin
			@(posedge clk);
			if (hold_req > 0) begin
				n = hold_req;
				hold_req = 0;
				out_ch.ready <= 0;
				repeat (n) @(posedge clk);
			end else if (idle_en && $urandom_range(0, 3) == 0) begin
				out_ch.ready <= 0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end
			out_ch.ready <= 1;
		end
	end

	function automatic int unsigned schedule_steps(int unsigned n);
		int unsigned s, f;
		if (n < 1) n = 1;
		if (n > MAX_RANKS) n = MAX_RANKS;
		s = 0;
		for (f = 2; f * f <= n; f++)
			while (n % f == 0) begin
				s += f - 1;
				n /= f;
			end
		if (n > 1) s += n - 1;
		return s;
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [63:0] value);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
	endtask

	task automatic drain();
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic configure(int unsigned ranks, int unsigned len, int unsigned ebytes,
			int unsigned cnote, int unsigned rnote, logic [39:0] rbase, logic [39:0] cbase);
		cur_ranks = ranks;
		write_reg(REG_NUM_RANKS, ranks);
		write_reg(REG_RANK_INDEX, $urandom_range(0, 63));
		write_reg(REG_TOTAL_LENGTH, len);
		write_reg(REG_ELEM_BYTES, ebytes);
		write_reg(REG_COMM_NOTE, cnote);
		write_reg(REG_REDUCE_NOTE, rnote);
		write_reg(REG_REDUCE_BASE, {24'($urandom), rbase});
		write_reg(REG_COMM_BASE, {24'($urandom), cbase});
		@(posedge clk);
	endtask

	task automatic send_phase(int unsigned p);
		if (idle_en && $urandom_range(0, 3) == 0) begin
			in_ch.valid <= 0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_ch.valid <= 1;
		in_ch.phase_index <= 7'(p);
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic run_phases(int count);
		int unsigned S;
		S = schedule_steps(cur_ranks);
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(0, 9) < 8) send_phase($urandom_range(0, 2 * S + 1));
			else send_phase($urandom_range(0, 127));
		end
		in_ch.valid <= 0;
		drain();
	endtask

	initial begin
		int unsigned r, count;
		int unsigned small_ranks[8] = '{2, 3, 4, 6, 8, 12, 30, 16};
		arst_n = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = 0;
		pwdata = 0;
		in_ch.valid = 0;
		in_ch.phase_index = 0;
		idle_en = 1;
		hold_req = 0;
		cur_ranks = 1;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// defaults, then single rank and every phase of a two-level schedule
		send_phase(0);
		send_phase(1);
		in_ch.valid <= 0;
		drain();
		configure(6, 32'd1000, 4, 16'hfffe, 16'hffff, 40'hff_ffff_ffff, 40'hff_ffff_fff0);
		for (int p = 0; p <= 7; p++) send_phase(p);
		send_phase(127);
		in_ch.valid <= 0;
		drain();
		configure(0, 32'hffff_ffff, 15, 0, 0, 0, 0);
		send_phase(0);
		send_phase(1);
		in_ch.valid <= 0;
		drain();
		configure(100, 32'hffff_ffff, 8, 1, 2, 40'h12_3456_789a, 40'h1);
		for (int p = 0; p <= 12; p++) send_phase(p);
		in_ch.valid <= 0;
		drain();

		configure(5, 32'd7, 0, 10, 20, 40'h100, 40'h200);
		hold_req = 400;
		run_phases(20);

		for (int round = 0; round < 30; round++) begin
			idle_en = (round < 25);
			case ($urandom_range(0, 9))
				0: r = 61;
				1: r = 64;
				2: r = $urandom_range(0, 127);
				default: r = small_ranks[$urandom_range(0, 7)];
			endcase
			count = (r == 61 || (r > 40 && r < 64)) ? 6 : 20;
			configure(r,
				($urandom_range(0, 3) == 0) ? 32'hffff_ffff : $urandom_range(0, 5000),
				$urandom_range(0, 15), $urandom_range(0, 65535), $urandom_range(0, 65535),
				40'({$urandom, $urandom}), 40'({$urandom, $urandom}));
			run_phases(count);
		end

		repeat (50) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/arsg_pkg.sv
rtl/arsg_chan_if.sv
rtl/arsg_div.sv
rtl/allreduce_ring_schedule_generator.sv
test/arsg_schedule_checker.sv
test/allreduce_ring_schedule_generator_test.sv
